>>> design/rcw_pkg.sv
// Shared constants, types and the code generator function of the rolling-code window checker.
package rcw_pkg;

    localparam int CODE_W     = 23;
    localparam int STATUS_W   = 3;
    localparam int SHIFT_W    = 9;
    localparam int WINDOW_DEF = 256;

    localparam logic [CODE_W-1:0] LCG_MUL    = CODE_W'(153);
    localparam logic [CODE_W-1:0] LCG_ADD    = CODE_W'(11);
    localparam logic [CODE_W-1:0] SEED_RESET = CODE_W'(425);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ZERO_CODE = 3'd2,
        ST_REINIT    = 3'd3,
        ST_NOT_INIT  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_CH,
        S_INIT_FILL,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_CHAL_RD,
        S_CHAL_LD,
        S_DONE
    } t_state;

    // One step of the 23-bit generator; the product wraps modulo 2^23.
    function automatic logic [CODE_W-1:0] lcg_next(input logic [CODE_W-1:0] s);
        logic [CODE_W-1:0] prod;
        prod = s * LCG_MUL;
        return prod + LCG_ADD;
    endfunction

endpackage

>>> design/rcw_in_if.sv
// Input channel of the rolling-code window checker: command and offered code.
interface rcw_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [rcw_pkg::CODE_W-1:0] received_code;

    modport source (output valid, output command, output received_code, input ready);
    modport sink   (input valid, input command, input received_code, output ready);
endinterface

>>> design/rcw_out_if.sv
// Result channel of the rolling-code window checker.
interface rcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcw_pkg::STATUS_W-1:0] status;
    logic [rcw_pkg::SHIFT_W-1:0]  shift_count;
    logic [rcw_pkg::CODE_W-1:0]   challenge_code;

    modport source (output valid, output status, output shift_count,
                    output challenge_code, input ready);
    modport sink   (input valid, input status, input shift_count,
                    input challenge_code, output ready);
endinterface

>>> design/rcw_cfg_if.sv
// Configuration write channel of the rolling-code window checker: the seed register.
interface rcw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rcw_pkg::CODE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/rolling_code_window_checker_top.sv
// Each input transfer yields one registered result: an init rebuilds the whole window, a
// refused offer goes straight to the result, and a check searches the window position by position.
// Throughput: one item at a time; the next transfer is taken once the result is registered and
// the block is back in idle, so the search and the shift loop set the pace.
// Reset (synchronous, active low) clears the control state and loads the seed with 425;
// the window memory is not cleared, and no read of it happens before the first init.
module rolling_code_window_checker_top #(
    parameter int WINDOW = rcw_pkg::WINDOW_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rcw_in_if.sink    i_cmd,
    rcw_out_if.source o_res,
    rcw_cfg_if.sink   i_cfg
);
    import rcw_pkg::*;

    // Index width for the window memory and the last valid index.
    localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SHW  = (IW + 1 > SHIFT_W) ? IW + 1 : SHIFT_W;
    localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);

    // The acceptance window lives in one synchronous memory. The front of the
    // window sits at r_head and the window wraps around the memory.
    logic [CODE_W-1:0] window_mem [WINDOW];
    logic [CODE_W-1:0] r_rdata;

    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [CODE_W-1:0] mem_wd;
    logic              mem_re;
    logic [IW-1:0]     mem_ra;

    // Control state.
    t_state            r_state, n_state;
    logic              r_win_ok, n_win_ok;
    logic [IW-1:0]     r_head, n_head;
    logic [CODE_W-1:0] r_tail, n_tail;
    logic [CODE_W-1:0] r_chal, n_chal;
    logic [CODE_W-1:0] r_seed, n_seed;

    // Working registers for one item. r_ptr is the memory address under
    // search or fill, r_p the window position (or remaining shifts).
    logic [CODE_W-1:0] r_code, n_code;
    logic [IW-1:0]     r_ptr, n_ptr;
    logic [IW-1:0]     r_p, n_p;
    t_status           r_status, n_status;
    logic [SHIFT_W-1:0] r_shift, n_shift;

    // Output register, so a finished result may wait while the next item is taken.
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [SHIFT_W-1:0] r_out_shift, n_out_shift;
    logic [CODE_W-1:0]  r_out_chal, n_out_chal;

    logic              in_xfer;
    logic              out_xfer;
    logic [CODE_W-1:0] lcg_q;
    logic [SHW-1:0]    shift_sum;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
        return (x == LAST) ? '0 : x + IW'(1);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign out_xfer    = r_out_valid && o_res.ready;

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.shift_count    = r_out_shift;
    assign o_res.challenge_code = r_out_chal;

    // One shared generator step: it starts from the seed when an init is taken
    // and from the current tail code everywhere else.
    assign lcg_q = lcg_next((r_state == S_IDLE) ? r_seed : r_tail);

    // Shift count is p+1, kept to its low nine bits for large windows.
    assign shift_sum = SHW'(r_p) + SHW'(1);

    always_comb begin
        n_state      = r_state;
        n_win_ok     = r_win_ok;
        n_head       = r_head;
        n_tail       = r_tail;
        n_chal       = r_chal;
        n_seed       = r_seed;
        n_code       = r_code;
        n_ptr        = r_ptr;
        n_p          = r_p;
        n_status     = r_status;
        n_shift      = r_shift;
        n_out_valid  = r_out_valid && !out_xfer;
        n_out_status = r_out_status;
        n_out_shift  = r_out_shift;
        n_out_chal   = r_out_chal;

        mem_we = 1'b0;
        mem_wa = r_head;
        mem_wd = lcg_q;
        mem_re = 1'b0;
        mem_ra = r_ptr;

        if (i_cfg.valid && i_cfg.ready) begin
            n_seed = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_shift = '0;
                    if (!i_cmd.command) begin
                        // First generator step from the seed.
                        n_tail  = lcg_q;
                        n_state = S_INIT_CH;
                    end else if (!r_win_ok) begin
                        n_status = ST_NOT_INIT;
                        n_state  = S_DONE;
                    end else if (i_cmd.received_code == '0) begin
                        n_status = ST_ZERO_CODE;
                        n_state  = S_DONE;
                    end else begin
                        n_code  = i_cmd.received_code;
                        n_ptr   = r_head;
                        n_p     = '0;
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_INIT_CH: begin
                // Second step gives the challenge; the window follows it.
                n_chal  = lcg_q;
                n_tail  = lcg_q;
                n_ptr   = '0;
                n_state = S_INIT_FILL;
            end
            S_INIT_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                n_tail = lcg_q;
                if (r_ptr == LAST) begin
                    n_head   = '0;
                    n_win_ok = 1'b1;
                    n_status = ST_REINIT;
                    n_state  = S_DONE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_SRCH_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_ptr;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (r_rdata == r_code) begin
                    n_shift = shift_sum[SHIFT_W-1:0];
                    n_state = S_SHIFT;
                end else if (r_p == LAST) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_p     = r_p + IW'(1);
                    n_ptr   = idx_inc(r_ptr);
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT: begin
                // Drop the front and append the successor of the tail in its slot.
                mem_we = 1'b1;
                mem_wa = r_head;
                n_tail = lcg_q;
                n_head = idx_inc(r_head);
                if (r_p == '0) begin
                    n_state = S_CHAL_RD;
                end else begin
                    n_p = r_p - IW'(1);
                end
            end
            S_CHAL_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_head;
                n_state = S_CHAL_LD;
            end
            S_CHAL_LD: begin
                n_chal   = r_rdata;
                n_status = ST_ACCEPTED;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_shift  = r_shift;
                    n_out_chal   = r_chal;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            window_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= window_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_ok    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_chal      <= '0;
            r_seed      <= SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win_ok    <= n_win_ok;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_chal      <= n_chal;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code       <= n_code;
        r_ptr        <= n_ptr;
        r_p          <= n_p;
        r_status     <= n_status;
        r_shift      <= n_shift;
        r_out_status <= n_out_status;
        r_out_shift  <= n_out_shift;
        r_out_chal   <= n_out_chal;
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the rolling-code window checker: directed table plus random offers.
module tb_top;

    import rcw_pkg::*;

    localparam int WIN       = WINDOW_DEF;
    localparam int IDLE_PCT  = 8;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 144;
    localparam int SETTLE    = 4;
    localparam int TAIL_WAIT = 3 * WIN + 8;

    localparam logic CMD_INIT  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    // One result of the block, in the order the result channel carries its fields.
    typedef struct packed {
        t_status             status;
        logic [SHIFT_W-1:0]  shift;
        logic [CODE_W-1:0]   challenge;
    } t_verdict;

    // A directed row either writes the seed, rebuilds the window, offers a literal code,
    // or offers the code that sits at a given distance from the window front.
    typedef enum logic [1:0] {
        R_SEED,
        R_INIT,
        R_OFFER,
        R_SLOT
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [CODE_W-1:0]  value;
        logic               typed;
        t_verdict           want;
    } t_plan_row;

    localparam t_verdict NO_VERDICT = '{ST_ACCEPTED, 9'd0, 23'd0};

    // Seed 0 gives the challenge 153 * 11 + 11 = 1694 after a rebuild.
    localparam int NUM_ROWS = 23;
    localparam t_plan_row PLAN [NUM_ROWS] = '{
        '{R_OFFER, 23'd1,       1'b1, '{ST_NOT_INIT, 9'd0, 23'd0}},
        '{R_OFFER, 23'd0,       1'b1, '{ST_NOT_INIT, 9'd0, 23'd0}},
        '{R_OFFER, CODE_MAX,    1'b1, '{ST_NOT_INIT, 9'd0, 23'd0}},
        '{R_INIT,  23'd0,       1'b0, NO_VERDICT},
        '{R_OFFER, 23'd0,       1'b0, NO_VERDICT},
        '{R_SLOT,  23'd0,       1'b0, NO_VERDICT},
        '{R_SLOT,  23'd255,     1'b0, NO_VERDICT},
        '{R_OFFER, CODE_MAX,    1'b0, NO_VERDICT},
        '{R_OFFER, 23'd1,       1'b0, NO_VERDICT},
        '{R_SEED,  23'd0,       1'b0, NO_VERDICT},
        '{R_INIT,  23'd0,       1'b1, '{ST_REINIT, 9'd0, 23'd1694}},
        '{R_OFFER, 23'd0,       1'b1, '{ST_ZERO_CODE, 9'd0, 23'd1694}},
        '{R_SLOT,  23'd0,       1'b0, NO_VERDICT},
        '{R_SEED,  CODE_MAX,    1'b0, NO_VERDICT},
        '{R_SLOT,  23'd10,      1'b0, NO_VERDICT},
        '{R_INIT,  CODE_MAX,    1'b0, NO_VERDICT},
        '{R_SLOT,  23'd128,     1'b0, NO_VERDICT},
        '{R_SLOT,  23'd255,     1'b0, NO_VERDICT},
        '{R_SLOT,  23'd0,       1'b0, NO_VERDICT},
        '{R_OFFER, 23'h400000,  1'b0, NO_VERDICT},
        '{R_INIT,  23'h2AAAAA,  1'b0, NO_VERDICT},
        '{R_SLOT,  23'd1,       1'b0, NO_VERDICT},
        '{R_SEED,  SEED_RESET,  1'b0, NO_VERDICT}
    };

    logic clk = 1'b0;
    logic rst_n;

    rcw_in_if  cmd_ch ();
    rcw_out_if res_ch ();
    rcw_cfg_if cfg_ch ();

    rolling_code_window_checker_top #(
        .WINDOW (WIN)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the receiver state: acceptance window, its front, the newest code,
    // the current challenge and whether a rebuild has happened yet.
    logic [CODE_W-1:0] win_mem [WIN];
    int                win_head;
    logic [CODE_W-1:0] win_tail;
    logic [CODE_W-1:0] chal;
    bit                armed;
    logic [CODE_W-1:0] seed_reg;

    t_verdict verdict_q [$];
    t_verdict got;
    t_verdict want;
    int       errors = 0;
    bit       calm;

    function automatic logic [CODE_W-1:0] next_code(input logic [CODE_W-1:0] s);
        return CODE_W'((64'(s) * 64'(LCG_MUL) + 64'(LCG_ADD)) % 64'd8388608);
    endfunction

    // Apply one command to the shadow state and return the result it must produce.
    function automatic t_verdict judge_command(input logic cmd, input logic [CODE_W-1:0] code);
        t_verdict          v;
        int                p;
        int                hit;
        logic [CODE_W-1:0] c;
        v.shift = '0;
        hit = -1;
        if (cmd == CMD_INIT) begin
            c = next_code(next_code(seed_reg));
            chal = c;
            for (p = 0; p < WIN; p++) begin
                c = next_code(c);
                win_mem[p] = c;
            end
            win_tail = c;
            win_head = 0;
            armed = 1'b1;
            v.status = ST_REINIT;
        end else if (!armed) begin
            v.status = ST_NOT_INIT;
        end else if (code == '0) begin
            v.status = ST_ZERO_CODE;
        end else begin
            for (p = 0; p < WIN && hit < 0; p++) begin
                if (win_mem[(win_head + p) % WIN] == code) hit = p;
            end
            if (hit < 0) begin
                v.status = ST_NOT_FOUND;
            end else begin
                // Drop everything up to and including the match, extending the tail.
                for (p = 0; p <= hit; p++) begin
                    win_tail = next_code(win_tail);
                    win_mem[win_head] = win_tail;
                    win_head = (win_head + 1) % WIN;
                end
                chal = win_mem[win_head];
                v.shift = SHIFT_W'(hit + 1);
                v.status = ST_ACCEPTED;
            end
        end
        v.challenge = chal;
        return v;
    endfunction

    // Present one command, wait for its transfer, then record the result it must give.
    // A row with a typed result queues that instead of the computed one.
    task automatic transfer_item(input logic cmd, input logic [CODE_W-1:0] code,
                                 input logic typed, input t_verdict typed_v);
        t_verdict v;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= cmd;
        cmd_ch.received_code <= code;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        v = judge_command(cmd, code);
        verdict_q.insert(verdict_q.size(), typed ? typed_v : v);
    endtask

    // The seed is only written with the block idle: every result drained, then the SETTLE wait.
    task automatic write_seed(input logic [CODE_W-1:0] value);
        cmd_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        seed_reg = value;
    endtask

    // Result side: random back-pressure, and each transfer checked against the oldest
    // expectation field by field.
    always @(posedge clk) begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = '{t_status'(res_ch.status), res_ch.shift_count, res_ch.challenge_code};
            if (verdict_q.size() == 0) begin
                $display("%0t: result with none expected: status %0d shift %0d challenge %0d",
                         $time, got.status, got.shift, got.challenge);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
                if (got.shift !== want.shift) begin
                    $display("%0t: shift_count mismatch: expected %0d, actual %0d",
                             $time, want.shift, got.shift);
                    errors++;
                end
                if (got.challenge !== want.challenge) begin
                    $display("%0t: challenge_code mismatch: expected %0d, actual %0d",
                             $time, want.challenge, got.challenge);
                    errors++;
                end
            end
        end
    end

    initial begin
        #60000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                ph;
        int                n;
        int                roll;
        int                off;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] seed_val;

        calm     = 1'b0;
        armed    = 1'b0;
        win_head = 0;
        win_tail = '0;
        chal     = '0;
        seed_reg = SEED_RESET;

        rst_n                <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.command       <= CMD_CHECK;
        cmd_ch.received_code <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: offers before any rebuild, the seed extremes, zero codes,
        // matches at the front and at the very end of the window, and misses.
        for (n = 0; n < NUM_ROWS; n++) begin
            case (PLAN[n].kind)
                R_SEED: begin
                    write_seed(PLAN[n].value);
                end
                R_INIT: begin
                    transfer_item(CMD_INIT, PLAN[n].value, PLAN[n].typed, PLAN[n].want);
                end
                R_OFFER: begin
                    transfer_item(CMD_CHECK, PLAN[n].value, PLAN[n].typed, PLAN[n].want);
                end
                default: begin
                    transfer_item(CMD_CHECK, win_mem[(win_head + int'(PLAN[n].value)) % WIN],
                                  PLAN[n].typed, PLAN[n].want);
                end
            endcase
        end

        // Random part: each phase drains, writes a new seed and rebuilds. Most offers are
        // genuine codes from the window, mostly close to the front; the rest are misses,
        // zero codes, near misses and stray rebuilds. One phase runs without any idling.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: seed_val = CODE_MAX;
                1: seed_val = '0;
                2: seed_val = SEED_RESET;
                default: seed_val = CODE_W'($urandom);
            endcase
            calm = 1'b0;
            write_seed(seed_val);
            calm = (ph == 3);
            transfer_item(CMD_INIT, CODE_W'($urandom), 1'b0, NO_VERDICT);
            for (n = 1; n < PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    transfer_item(CMD_INIT, CODE_W'($urandom), 1'b0, NO_VERDICT);
                end else begin
                    if (roll < 66) begin
                        roll = $urandom_range(99);
                        if (roll < 80) off = $urandom_range(7);
                        else if (roll < 95) off = $urandom_range(63, 8);
                        else off = $urandom_range(WIN - 1, 64);
                        code = win_mem[(win_head + off) % WIN];
                    end else if (roll < 76) begin
                        code = CODE_W'($urandom);
                    end else if (roll < 81) begin
                        code = '0;
                    end else if (roll < 88) begin
                        // The code just past the window tail must be refused.
                        code = next_code(win_tail);
                    end else if (roll < 95) begin
                        // A genuine code with one bit flipped.
                        code = win_mem[(win_head + $urandom_range(WIN - 1)) % WIN];
                        code[$urandom_range(CODE_W - 1)] ^= 1'b1;
                    end else begin
                        code = $urandom_range(1) ? CODE_MAX : CODE_W'($urandom_range(3));
                    end
                    transfer_item(CMD_CHECK, code, 1'b0, NO_VERDICT);
                end
            end
        end

        calm = 1'b0;
        cmd_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rcw_pkg.sv
design/rcw_in_if.sv
design/rcw_out_if.sv
design/rcw_cfg_if.sv
design/rolling_code_window_checker_top.sv
tb/tb_top.sv
